FILE: hw/rtl/spt_pkg.sv
// Shared types and codes for the sorted priority task list.
// Holds the entry and control structs and the command and status codes.
// No dependencies.
`default_nettype none

package spt_pkg;

  localparam int unsigned TagW = 16;
  localparam int unsigned PriW = 16;
  localparam int unsigned PosW = 8;
  localparam int unsigned InW  = TagW + PriW + PosW;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_DEL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_BELOW = 2'd2,
    ST_PAST  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [PriW-1:0] pri;
    logic [TagW-1:0]        tag;
  } entry_t;

  // Broadcast to every cell while a request updates the chain.
  typedef struct packed {
    logic            en;
    logic            del;
    entry_t          item;
    logic [PosW-1:0] pos;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spt_cell.sv
// One slot of the sorted task chain: holds one entry, compares it with a new
// task and takes data from its left or right neighbor. Uses spt_pkg.
`default_nettype none

module spt_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire             clk_i,
  input  spt_pkg::ctrl_t  ctrl_i,
  input  wire             occ_i,
  input  wire             keep_head_i,
  input  spt_pkg::entry_t left_i,
  input  wire             left_stay_i,
  input  spt_pkg::entry_t right_i,
  output spt_pkg::entry_t entry_o,
  output logic            stay_o,
  output spt_pkg::entry_t removed_o
);

  localparam logic [spt_pkg::PosW:0] IdxP1 = (spt_pkg::PosW+1)'(Idx + 1);

  spt_pkg::entry_t entry_q, entry_d;
  logic            ge;
  logic            hit;
  logic            take_right;

  // The head slot keeps its place only on a strictly higher priority.
  always_comb begin
    if (Idx == 0) begin
      ge = $signed(entry_q.pri) > $signed(ctrl_i.item.pri);
    end else begin
      ge = $signed(entry_q.pri) >= $signed(ctrl_i.item.pri);
    end
  end

  assign stay_o     = keep_head_i && occ_i && ge;
  assign hit        = {1'b0, ctrl_i.pos} == IdxP1;
  assign take_right = {1'b0, ctrl_i.pos} <= IdxP1;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.en) begin
      if (ctrl_i.del) begin
        if (take_right) entry_d = right_i;
      end else if (!stay_o) begin
        entry_d = left_stay_i ? ctrl_i.item : left_i;
      end
    end
  end

  assign removed_o = (ctrl_i.en && ctrl_i.del && hit) ? entry_q : '0;
  assign entry_o   = entry_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_priority_task_list.sv
// A request is captured in S_IDLE; S_EXEC then updates the cell chain and loads the output register.
// No new request is taken until the last one has left S_EXEC: s_axis_tready_o is high only in S_IDLE.
// The update cycle waits while an earlier result is still held on the output.
// Reset clears the entry count, the held request, the state machine and the output register.
// Slot contents are not cleared; only slots below the count are ever read.
// Sorted priority task list: top level. Instantiates spt_cell; uses spt_pkg.
`default_nettype none

module sorted_priority_task_list #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CntW = $clog2(CAPACITY + 1),
  localparam int unsigned OutW = ((66 + CntW + 7) / 8) * 8
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // task_tag [15:0], task_prio [31:16], position [39:32]
  input  wire  [spt_pkg::InW-1:0]   s_axis_tdata_i,
  // command [0]
  input  wire  [0:0]                s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire                       m_axis_tready_i,
  // status [1:0], removed_tag [17:2], removed_priority [33:18],
  // entry_count [33+CntW:34], head_tag, head_priority, zero pad
  output logic [OutW-1:0]           m_axis_tdata_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  state_e                  state_q;
  logic [CntW-1:0]         count_q;
  logic                    m_valid_q;
  logic [OutW-1:0]         m_data_q;
  spt_pkg::cmd_e           cmd_q;
  spt_pkg::entry_t         item_q;
  logic [spt_pkg::PosW-1:0] pos_q;

  spt_pkg::entry_t         cell_ent [CAPACITY];
  spt_pkg::entry_t         cell_rem [CAPACITY];
  logic [CAPACITY-1:0]     stay;
  logic [CAPACITY-1:0]     occ;
  spt_pkg::ctrl_t          ctrl;

  spt_pkg::status_e        status;
  logic                    is_add;
  logic                    ok;
  logic                    out_free;
  logic                    fire;
  logic [CntW-1:0]         count_nxt;
  spt_pkg::entry_t         head_nxt;
  spt_pkg::entry_t         head_out;
  spt_pkg::entry_t         removed;

  // ---------------------------------------------------------------------
  // Decode the held request and judge it against the current count
  // ---------------------------------------------------------------------
  assign is_add = cmd_q == spt_pkg::CMD_ADD;

  always_comb begin
    if (is_add) begin
      status = (count_q == CapCnt) ? spt_pkg::ST_FULL : spt_pkg::ST_DONE;
    end else if (pos_q == '0) begin
      status = spt_pkg::ST_BELOW;
    end else if ({1'b0, pos_q} > (spt_pkg::PosW+1)'(count_q)) begin
      status = spt_pkg::ST_PAST;
    end else begin
      status = spt_pkg::ST_DONE;
    end
  end

  assign ok       = status == spt_pkg::ST_DONE;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign fire     = (state_q == S_EXEC) && out_free;

  // Only a request that succeeds moves the chain.
  assign ctrl.en   = fire && ok;
  assign ctrl.del  = !is_add;
  assign ctrl.item = item_q;
  assign ctrl.pos  = pos_q;

  // ---------------------------------------------------------------------
  // Cell chain: each slot knows whether it is occupied from the count
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign occ[g] = count_q > CntW'(g);

    if (g == 0) begin : g_head
      spt_cell #(.Idx(g)) u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .occ_i       (occ[g]),
        .keep_head_i (1'b1),
        .left_i      (item_q),
        .left_stay_i (1'b1),
        .right_i     (cell_ent[g+1]),
        .entry_o     (cell_ent[g]),
        .stay_o      (stay[g]),
        .removed_o   (cell_rem[g])
      );
    end else if (g == CAPACITY - 1) begin : g_tail
      spt_cell #(.Idx(g)) u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .occ_i       (occ[g]),
        .keep_head_i (stay[0]),
        .left_i      (cell_ent[g-1]),
        .left_stay_i (stay[g-1]),
        .right_i     ('0),
        .entry_o     (cell_ent[g]),
        .stay_o      (stay[g]),
        .removed_o   (cell_rem[g])
      );
    end else begin : g_mid
      spt_cell #(.Idx(g)) u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .occ_i       (occ[g]),
        .keep_head_i (stay[0]),
        .left_i      (cell_ent[g-1]),
        .left_stay_i (stay[g-1]),
        .right_i     (cell_ent[g+1]),
        .entry_o     (cell_ent[g]),
        .stay_o      (stay[g]),
        .removed_o   (cell_rem[g])
      );
    end
  end

  // At most one cell flags a removal; merge them.
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | cell_rem[i];
    end
  end

  // ---------------------------------------------------------------------
  // Result: count and head as they stand after this request
  // ---------------------------------------------------------------------
  always_comb begin
    if (!ok) begin
      count_nxt = count_q;
    end else if (is_add) begin
      count_nxt = count_q + CntW'(1);
    end else begin
      count_nxt = count_q - CntW'(1);
    end
  end

  always_comb begin
    head_nxt = cell_ent[0];
    if (ok) begin
      if (is_add) begin
        if (!stay[0]) head_nxt = item_q;
      end else if (pos_q == spt_pkg::PosW'(1)) begin
        head_nxt = cell_ent[1];
      end
    end
  end

  assign head_out = (count_nxt != '0) ? head_nxt : '0;

  // ---------------------------------------------------------------------
  // Control: capture a request, then update the chain and load the result
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      cmd_q     <= spt_pkg::CMD_ADD;
      item_q    <= '0;
      pos_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          // Drop the result once the receiver takes it.
          if (m_axis_tready_i) m_valid_q <= 1'b0;
          if (s_axis_tvalid_i) begin
            cmd_q   <= spt_pkg::cmd_e'(s_axis_tuser_i[0]);
            item_q  <= s_axis_tdata_i[31:0];
            pos_q   <= s_axis_tdata_i[39:32];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          // Hold while an earlier result is still waiting on the output.
          if (out_free) begin
            count_q   <= count_nxt;
            m_valid_q <= 1'b1;
            m_data_q  <= OutW'({head_out.pri, head_out.tag, count_nxt,
                                removed.pri, removed.tag, status});
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/spt_checker.sv
// Port-level checks for the sorted priority task list, bound to the top level.
// Uses spt_pkg status codes.
`default_nettype none

module spt_checker #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CntW = $clog2(CAPACITY + 1),
  localparam int unsigned OutW = ((66 + CntW + 7) / 8) * 8
) (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            s_axis_tvalid_i,
  input wire            s_axis_tready_o,
  input wire            m_axis_tvalid_o,
  input wire            m_axis_tready_i,
  input wire [OutW-1:0] m_axis_tdata_o
);

  logic [1:0]      st;
  logic [31:0]     rem;
  logic [CntW-1:0] cnt;

  assign st  = m_axis_tdata_o[1:0];
  assign rem = m_axis_tdata_o[33:2];
  assign cnt = m_axis_tdata_o[34 +: CntW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another is in progress");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> cnt <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_no_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st != spt_pkg::ST_DONE |-> rem == '0)
    else $error("removed entry reported on a failed request");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == spt_pkg::ST_FULL |-> cnt == CntW'(CAPACITY))
    else $error("store full reported below capacity");

endmodule

bind sorted_priority_task_list spt_checker #(.CAPACITY(CAPACITY)) u_spt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
